@@ hdl/hc_pkg.sv @@
// Shared constants, types and mod-26 helper functions for the 2x2 Hill cipher.
// No dependencies; every other file of the block refers to this package by scoped names.
package hc_pkg;

   localparam int unsigned MOD    = 26;
   localparam int          VAL_W  = 5;
   localparam int          CHAR_W = 8;
   localparam int          SUM_W  = 11;
   localparam int          PROD_W = 10;
   localparam int          IDX_W  = 3;
   localparam int          DATA_W = 5;

   // Reciprocal of 26 scaled by 2^16, rounded up; exact quotient for any 11-bit dividend.
   localparam int          RECIP_SHIFT = 16;
   localparam int          RECIP_W     = SUM_W + 12;
   localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / MOD + 1;

   localparam logic [VAL_W-1:0]  MOD_VAL  = VAL_W'(MOD);
   localparam logic [VAL_W-1:0]  UNIT_VAL = VAL_W'(1);
   localparam logic [SUM_W-1:0]  DET_BIAS = SUM_W'(MOD * MOD);

   localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_Z = 8'h7a;
   localparam logic [CHAR_W-1:0] CHAR_UC_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_Z = 8'h5a;

   // Register indexes of the configuration port
   localparam logic [IDX_W-1:0] REG_KEY_TOP_LEFT     = 3'd0;
   localparam logic [IDX_W-1:0] REG_KEY_TOP_RIGHT    = 3'd1;
   localparam logic [IDX_W-1:0] REG_KEY_BOTTOM_LEFT  = 3'd2;
   localparam logic [IDX_W-1:0] REG_KEY_BOTTOM_RIGHT = 3'd3;
   localparam logic [IDX_W-1:0] REG_DECRYPT_MODE     = 3'd4;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int PUSH_W     = 2;
   localparam int PUSH_MAX   = 2;

   localparam logic [PUSH_W-1:0] PUSH_NONE = 2'd0;
   localparam logic [PUSH_W-1:0] PUSH_ONE  = 2'd1;
   localparam logic [PUSH_W-1:0] PUSH_TWO  = 2'd2;

   typedef struct packed {
      logic             is_letter;
      logic [VAL_W-1:0] value;
   } letter_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              last_of_pair;
      logic              bad_key;
   } rsp_word_type;

   typedef struct packed {
      logic [PUSH_W-1:0] count;
      rsp_word_type      word0;
      rsp_word_type      word1;
   } push_type;

   // Effective key: matrix (adjugate when decrypting) and scale (inverse determinant when decrypting, else one)
   typedef struct packed {
      logic [VAL_W-1:0] m00;
      logic [VAL_W-1:0] m01;
      logic [VAL_W-1:0] m10;
      logic [VAL_W-1:0] m11;
      logic [VAL_W-1:0] scale;
      logic             bad;
   } key_state_type;

   function automatic letter_type letter_decode(input logic [CHAR_W-1:0] ch);
      letter_type res;
      res = '0;
      if (ch inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
         res.is_letter = 1'b1;
         res.value     = VAL_W'(ch - CHAR_LC_A);
      end else if (ch inside {[CHAR_UC_A:CHAR_UC_Z]}) begin
         res.is_letter = 1'b1;
         res.value     = VAL_W'(ch - CHAR_UC_A);
      end
      return res;
   endfunction

   // Fold a 5-bit register value into 0..25
   function automatic logic [VAL_W-1:0] reduce26(input logic [VAL_W-1:0] v);
      return (v >= MOD_VAL) ? VAL_W'(v - MOD_VAL) : v;
   endfunction

   // (26 - v) mod 26 for v in 0..25
   function automatic logic [VAL_W-1:0] neg26(input logic [VAL_W-1:0] v);
      return (v == '0) ? '0 : VAL_W'(MOD_VAL - v);
   endfunction

   // x mod 26 by reciprocal multiply and one back-multiply
   function automatic logic [VAL_W-1:0] mod26(input logic [SUM_W-1:0] x);
      logic [RECIP_W-1:0] prod;
      logic [SUM_W-1:0]   quo;
      logic [SUM_W-1:0]   rem;
      prod = RECIP_W'(x) * RECIP_W'(RECIP);
      quo  = SUM_W'(prod >> RECIP_SHIFT);
      rem  = x - quo * SUM_W'(MOD);
      return rem[VAL_W-1:0];
   endfunction

   // Multiplicative inverse mod 26, zero when none exists
   function automatic logic [VAL_W-1:0] inv26(input logic [VAL_W-1:0] det);
      logic [VAL_W-1:0] inv;
      case (det)
         5'd1:    inv = 5'd1;
         5'd3:    inv = 5'd9;
         5'd5:    inv = 5'd21;
         5'd7:    inv = 5'd15;
         5'd9:    inv = 5'd3;
         5'd11:   inv = 5'd19;
         5'd15:   inv = 5'd7;
         5'd17:   inv = 5'd23;
         5'd19:   inv = 5'd11;
         5'd21:   inv = 5'd5;
         5'd23:   inv = 5'd17;
         5'd25:   inv = 5'd25;
         default: inv = 5'd0;
      endcase
      return inv;
   endfunction

endpackage

@@ hdl/hc_ifs.sv @@
// Valid/ready channel interfaces of the Hill cipher: text in, letters out, register writes.
// Payload widths come from hc_pkg.
interface hc_req_if;
   logic                      valid;
   logic                      ready;
   logic [hc_pkg::CHAR_W-1:0] in_char;
   logic                      end_of_text;
   modport source (output valid, in_char, end_of_text, input ready);
   modport sink   (input valid, in_char, end_of_text, output ready);
endinterface

interface hc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [hc_pkg::CHAR_W-1:0] out_char;
   logic                      last_of_pair;
   logic                      bad_key;
   modport source (output valid, out_char, last_of_pair, bad_key, input ready);
   modport sink   (input valid, out_char, last_of_pair, bad_key, output ready);
endinterface

interface hc_csr_if;
   logic                      valid;
   logic                      ready;
   logic [hc_pkg::IDX_W-1:0]  index;
   logic [hc_pkg::DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/hc_key_prep.sv @@
// Key registers and the derived decrypt key (adjugate, determinant, inverse).
// Depends on hc_pkg and hc_csr_if.
module hc_key_prep (
   input  logic                  clock,
   input  logic                  reset,
   hc_csr_if.sink                csr_if,
   output hc_pkg::key_state_type key_state
);

   logic [hc_pkg::VAL_W-1:0] key_tl_ff, key_tr_ff, key_bl_ff, key_br_ff;
   logic                     decrypt_ff;

   logic [hc_pkg::VAL_W-1:0] red_a, red_b, red_c, red_d;

   logic [hc_pkg::VAL_W-1:0] m00_ff, m01_ff, m10_ff, m11_ff;
   logic [hc_pkg::SUM_W-1:0] det_raw_ff, det_raw_in;
   logic                     dec1_ff;
   logic [hc_pkg::VAL_W-1:0] det_ff;
   logic                     dec2_ff;
   logic [hc_pkg::VAL_W-1:0] inv;
   logic [hc_pkg::VAL_W-1:0] scale_ff, scale_in;
   logic                     bad_ff, bad_in;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_tl_ff  <= hc_pkg::UNIT_VAL;
         key_tr_ff  <= '0;
         key_bl_ff  <= '0;
         key_br_ff  <= hc_pkg::UNIT_VAL;
         decrypt_ff <= 1'b0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            hc_pkg::REG_KEY_TOP_LEFT:     key_tl_ff  <= csr_if.data;
            hc_pkg::REG_KEY_TOP_RIGHT:    key_tr_ff  <= csr_if.data;
            hc_pkg::REG_KEY_BOTTOM_LEFT:  key_bl_ff  <= csr_if.data;
            hc_pkg::REG_KEY_BOTTOM_RIGHT: key_br_ff  <= csr_if.data;
            hc_pkg::REG_DECRYPT_MODE:     decrypt_ff <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   assign red_a = hc_pkg::reduce26(key_tl_ff);
   assign red_b = hc_pkg::reduce26(key_tr_ff);
   assign red_c = hc_pkg::reduce26(key_bl_ff);
   assign red_d = hc_pkg::reduce26(key_br_ff);

   assign det_raw_in = hc_pkg::SUM_W'(red_a) * hc_pkg::SUM_W'(red_d) + hc_pkg::DET_BIAS
                     - hc_pkg::SUM_W'(red_b) * hc_pkg::SUM_W'(red_c);

   assign inv      = hc_pkg::inv26(det_ff);
   assign scale_in = dec2_ff ? inv : hc_pkg::UNIT_VAL;
   assign bad_in   = dec2_ff && (inv == '0);

   // Derived key runs continuously: matrix and determinant, then reduce, then invert
   always_ff @(posedge clock) begin
      if (decrypt_ff) begin
         m00_ff <= red_d;
         m01_ff <= hc_pkg::neg26(red_b);
         m10_ff <= hc_pkg::neg26(red_c);
         m11_ff <= red_a;
      end else begin
         m00_ff <= red_a;
         m01_ff <= red_b;
         m10_ff <= red_c;
         m11_ff <= red_d;
      end
      det_raw_ff <= det_raw_in;
      dec1_ff    <= decrypt_ff;
      det_ff     <= hc_pkg::mod26(det_raw_ff);
      dec2_ff    <= dec1_ff;
      scale_ff   <= scale_in;
      bad_ff     <= bad_in;
   end

   assign key_state.m00   = m00_ff;
   assign key_state.m01   = m01_ff;
   assign key_state.m10   = m10_ff;
   assign key_state.m11   = m11_ff;
   assign key_state.scale = scale_ff;
   assign key_state.bad   = bad_ff;

endmodule

@@ hdl/hc_datapath.sv @@
// Byte pairing and mod-26 matrix pipeline; hands zero, one or two words to the result queue.
// Depends on hc_pkg and hc_req_if.
module hc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   hc_req_if.sink                req_if,
   input  hc_pkg::key_state_type key_state,
   input  logic                  room,
   output hc_pkg::push_type      push
);

   logic adv;

   // Input register
   logic                      in0_valid_ff;
   logic [hc_pkg::CHAR_W-1:0] in0_char_ff;
   logic                      in0_eot_ff;

   // Pairing state
   hc_pkg::letter_type       letter;
   logic                     phase_ff, phase_in;
   logic [hc_pkg::VAL_W-1:0] held_value_ff, held_value_in;
   logic                     held_letter_ff, held_letter_in;

   logic                     s1_valid_ff, s1_valid_in;
   logic [hc_pkg::VAL_W-1:0] s1_p0_ff, s1_p1_ff;

   logic                     s2_valid_ff;
   logic [hc_pkg::SUM_W-1:0] s2_raw0_ff, s2_raw1_ff, s2_raw0_in, s2_raw1_in;

   logic                     s3_valid_ff;
   logic [hc_pkg::VAL_W-1:0] s3_y0_ff, s3_y1_ff;

   logic                      s4_valid_ff;
   logic [hc_pkg::PROD_W-1:0] s4_z0_ff, s4_z1_ff, s4_z0_in, s4_z1_in;
   logic                      s4_bad_ff;

   logic [hc_pkg::VAL_W-1:0] q0, q1;

   // Whole pipeline moves together while the queue can take a full pair
   assign adv          = room;
   assign req_if.ready = adv;

   assign letter = hc_pkg::letter_decode(in0_char_ff);

   always_comb begin
      phase_in       = phase_ff;
      held_value_in  = held_value_ff;
      held_letter_in = held_letter_ff;
      s1_valid_in    = 1'b0;
      if (in0_valid_ff) begin
         if (!phase_ff) begin
            held_value_in  = letter.value;
            held_letter_in = letter.is_letter;
            phase_in       = !in0_eot_ff;
         end else begin
            phase_in    = 1'b0;
            s1_valid_in = held_letter_ff && letter.is_letter;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in0_valid_ff   <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
         phase_ff       <= 1'b0;
         held_value_ff  <= '0;
         held_letter_ff <= 1'b0;
      end else if (adv) begin
         in0_valid_ff   <= req_if.valid;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         s4_valid_ff    <= s3_valid_ff;
         phase_ff       <= phase_in;
         held_value_ff  <= held_value_in;
         held_letter_ff <= held_letter_in;
      end
   end

   assign s2_raw0_in = hc_pkg::SUM_W'(key_state.m00) * hc_pkg::SUM_W'(s1_p0_ff)
                     + hc_pkg::SUM_W'(key_state.m01) * hc_pkg::SUM_W'(s1_p1_ff);
   assign s2_raw1_in = hc_pkg::SUM_W'(key_state.m10) * hc_pkg::SUM_W'(s1_p0_ff)
                     + hc_pkg::SUM_W'(key_state.m11) * hc_pkg::SUM_W'(s1_p1_ff);

   assign s4_z0_in = hc_pkg::PROD_W'(key_state.scale) * hc_pkg::PROD_W'(s3_y0_ff);
   assign s4_z1_in = hc_pkg::PROD_W'(key_state.scale) * hc_pkg::PROD_W'(s3_y1_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         in0_char_ff <= req_if.in_char;
         in0_eot_ff  <= req_if.end_of_text;
         s1_p0_ff    <= held_value_ff;
         s1_p1_ff    <= letter.value;
         s2_raw0_ff  <= s2_raw0_in;
         s2_raw1_ff  <= s2_raw1_in;
         s3_y0_ff    <= hc_pkg::mod26(s2_raw0_ff);
         s3_y1_ff    <= hc_pkg::mod26(s2_raw1_ff);
         s4_z0_ff    <= s4_z0_in;
         s4_z1_ff    <= s4_z1_in;
         s4_bad_ff   <= key_state.bad;
      end
   end

   assign q0 = hc_pkg::mod26(hc_pkg::SUM_W'(s4_z0_ff));
   assign q1 = hc_pkg::mod26(hc_pkg::SUM_W'(s4_z1_ff));

   always_comb begin
      push       = '0;
      push.count = hc_pkg::PUSH_NONE;
      if (s4_bad_ff) begin
         push.word0.out_char     = '0;
         push.word0.last_of_pair = 1'b1;
         push.word0.bad_key      = 1'b1;
         if (s4_valid_ff && adv) begin
            push.count = hc_pkg::PUSH_ONE;
         end
      end else begin
         push.word0.out_char     = hc_pkg::CHAR_LC_A + hc_pkg::CHAR_W'(q0);
         push.word1.out_char     = hc_pkg::CHAR_LC_A + hc_pkg::CHAR_W'(q1);
         push.word1.last_of_pair = 1'b1;
         if (s4_valid_ff && adv) begin
            push.count = hc_pkg::PUSH_TWO;
         end
      end
   end

endmodule

@@ hdl/hc_out_fifo.sv @@
// Four-word result queue: takes up to two words per cycle, hands out one per cycle while rsp_if is ready.
// Depends on hc_pkg and hc_rsp_if.
module hc_out_fifo (
   input  logic             clock,
   input  logic             reset,
   input  hc_pkg::push_type push,
   hc_rsp_if.source         rsp_if,
   output logic             room
);

   hc_pkg::rsp_word_type         entries_ff [hc_pkg::FIFO_DEPTH];
   logic [hc_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hc_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hc_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic                          pop;
   hc_pkg::rsp_word_type          head;

   assign pop  = rsp_if.valid && rsp_if.ready;
   assign room = count_ff <= hc_pkg::FIFO_CNT_W'(hc_pkg::FIFO_DEPTH - hc_pkg::PUSH_MAX);

   assign wr_ptr_in = wr_ptr_ff + hc_pkg::FIFO_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + hc_pkg::FIFO_PTR_W'(pop);
   assign count_in  = count_ff + hc_pkg::FIFO_CNT_W'(push.count)
                    - hc_pkg::FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != hc_pkg::PUSH_NONE) begin
         entries_ff[wr_ptr_ff] <= push.word0;
      end
      if (push.count == hc_pkg::PUSH_TWO) begin
         entries_ff[wr_ptr_ff + hc_pkg::FIFO_PTR_W'(1)] <= push.word1;
      end
   end

   assign head                = entries_ff[rd_ptr_ff];
   assign rsp_if.valid        = count_ff != '0;
   assign rsp_if.out_char     = head.out_char;
   assign rsp_if.last_of_pair = head.last_of_pair;
   assign rsp_if.bad_key      = head.bad_key;

endmodule

@@ hdl/hill_cipher_2x2_mod26.sv @@
// Top level of the 2x2 Hill cipher over a text byte stream, modulo 26.
// Depends on hc_pkg, hc_ifs, hc_key_prep, hc_datapath and hc_out_fifo.
//
// Text bytes enter on req_if one per cycle while ready and are taken in fixed pairs.
// Letters of either case map to 0..25; a pair of two letters is multiplied by
// the key matrix (or, with decrypt_mode set, by its inverse mod 26) and leaves
// on rsp_if as two lowercase letters, last_of_pair marking the second. A pair
// holding any other byte gives nothing, and a first byte flagged end_of_text is
// dropped. When decrypting with a key whose determinant has no inverse, a
// letter pair gives a single word with out_char zero, bad_key and last_of_pair
// set. Key entries above 25 are folded mod 26. Throughput is one byte per
// cycle while req_if.ready is high: a pipeline (input register, pairing,
// products, mod 26, inverse scale, final mod 26) feeds a four-word result
// queue. The queue sets the pace: req_if.ready drops while it holds three or
// more words, so the text stream is stalled only when rsp_if is held off. The
// register port always accepts; the derived decrypt key (determinant, its
// inverse) is registered in steps after a write and settles well before any
// pair that follows can reach the stage that uses it. Write registers only
// while no result is outstanding.
module hill_cipher_2x2_mod26 (
   input  logic     clock,
   input  logic     reset,
   hc_req_if.sink   req_if,
   hc_rsp_if.source rsp_if,
   hc_csr_if.sink   csr_if
);

   hc_pkg::key_state_type key_state;
   hc_pkg::push_type      push;
   logic                  room;

   // Hold the key registers and derive the working matrix and scale
   hc_key_prep u_key_prep (
      .clock     (clock),
      .reset     (reset),
      .csr_if    (csr_if),
      .key_state (key_state)
   );

   // Pair up bytes and run the mod-26 matrix multiply; advance only with queue room
   hc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .key_state (key_state),
      .room      (room),
      .push      (push)
   );

   // Buffer up to two results per pair and drain them one word at a time
   hc_out_fifo u_out_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .rsp_if (rsp_if),
      .room   (room)
   );

endmodule
